/* src/verlet_particle_table_defines.svh */
// Assertion macros shared by the particle table checkers.
// Depends on signals named clock and reset in the module that uses them.
`ifndef VERLET_PARTICLE_TABLE_DEFINES_SVH
`define VERLET_PARTICLE_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define VPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define VPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/vpt_pkg.sv */
// Types, constants and saturating fixed-point helpers of the particle table.
// No dependencies; used by verlet_particle_table and vpt_checker.
package vpt_pkg;

   localparam int MAX_OBJECTS = 64;
   localparam int IDX_W       = $clog2(MAX_OBJECTS);
   localparam int FRAC_BITS   = 16;
   localparam int CSR_ADDR_W  = 2;

   // drag factor 0.02 in fixed point
   localparam logic signed [31:0] DRAG_Q = 32'(((64'sd1 << FRAC_BITS) + 25) / 50);
   localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

   localparam logic [2:0] ACT_SET_FLAGS   = 3'd0;
   localparam logic [2:0] ACT_SET_ACCEL   = 3'd1;
   localparam logic [2:0] ACT_ADD_FORCE   = 3'd2;
   localparam logic [2:0] ACT_PUSH        = 3'd3;
   localparam logic [2:0] ACT_CLEAR       = 3'd4;
   localparam logic [2:0] ACT_SYNC        = 3'd5;
   localparam logic [2:0] ACT_INTEGRATE   = 3'd6;
   localparam logic [2:0] ACT_RESET_FORCE = 3'd7;

   localparam int FLAG_NO_GRAVITY = 0;
   localparam int FLAG_STATIC     = 1;
   localparam int FLAG_DRAG       = 2;
   localparam int FLAG_PLAYER     = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_GRAVITY_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRAVITY_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRAVITY_Z = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OBJ_COUNT = 2'd3;

   localparam logic signed [31:0] GRAVITY_Y_RESET = -32'sd642908;

   typedef logic [2:0][31:0] vec3_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [IDX_W-1:0]  object_index;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic [3:0]        flag_bits;
      logic [30:0]       step_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               ok;
   } rsp_type;

   // one table entry
   typedef struct packed {
      vec3_type   last;
      vec3_type   accel;
      vec3_type   push;
      logic [3:0] flags;
   } entry_type;

   function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_sub(logic signed [31:0] a,
                                                  logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) - 33'(b);
      if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      return s[31:0];
   endfunction

   // round to nearest (ties up), drop fraction bits, saturate
   function automatic logic signed [31:0] round_sat(logic signed [63:0] prod);
      logic signed [63:0] q;
      q = (prod + HALF_LSB) >>> FRAC_BITS;
      if (q > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (q < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
      return q[31:0];
   endfunction

endpackage

/* src/verlet_particle_table.sv */
// Particle table with position Verlet integration, Q16.16 saturating math.
// Depends on vpt_pkg; the entry table is a one-port-read, one-port-write memory.
//
//  channel | ports                          | handshake
//  req     | start, busy, req_data          | accepted when start && !busy
//  rsp     | rsp_valid, rsp_data            | one-cycle strobe, never stalled
//  csr     | csr_we, csr_addr, csr_wdata    | written when csr_we is high
//
// One item at a time. Commands pass READ and EXEC; table actions, reset forces
// without drag, zero timestep, static integrate and a bad index answer from EXEC.
// Integrate runs AMUL to FIN per axis (PMUL to PADD first in player mode), drag
// runs DMUL to DSUB per axis, both then WB, on the single shared 32x32 multiplier.
// Synchronous reset clears control, config and per-entry valid bits at once.
// The next item may be accepted in the cycle its predecessor's result is shown.
module verlet_particle_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vpt_pkg::req_type req_data,
   output logic             rsp_valid,
   output vpt_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [vpt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]      csr_wdata
);
   import vpt_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_EXEC = 4'd2;
   localparam logic [3:0] ST_PMUL = 4'd3;
   localparam logic [3:0] ST_PRND = 4'd4;
   localparam logic [3:0] ST_PADD = 4'd5;
   localparam logic [3:0] ST_AMUL = 4'd6;
   localparam logic [3:0] ST_ARND = 4'd7;
   localparam logic [3:0] ST_BMUL = 4'd8;
   localparam logic [3:0] ST_BRND = 4'd9;
   localparam logic [3:0] ST_FIN  = 4'd10;
   localparam logic [3:0] ST_DMUL = 4'd11;
   localparam logic [3:0] ST_DRND = 4'd12;
   localparam logic [3:0] ST_DSUB = 4'd13;
   localparam logic [3:0] ST_WB   = 4'd14;

   // config registers
   logic signed [31:0] grav_x_ff, grav_y_ff, grav_z_ff;
   logic [6:0]         obj_count_ff;

   // control
   logic [3:0] state_ff, state_in;
   logic [1:0] ax_ff, ax_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [MAX_OBJECTS-1:0] valid_ff;

   // payload
   req_type   req_ff, req_in;
   entry_type work_ff, work_in;
   vec3_type  cur_ff, cur_in;
   vec3_type  pos_ff, pos_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] diff_ff, diff_in;
   logic signed [31:0] base_ff, base_in;

   // table memory
   entry_type mem [MAX_OBJECTS];
   entry_type rd_ff;
   logic      rd_valid_ff;
   logic      mem_we;
   entry_type mem_wdata;

   entry_type          ent;
   logic               idx_ok;
   logic signed [31:0] dt;
   logic signed [31:0] mul_a, mul_b;
   logic               player;

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign idx_ok = ({1'b0, req_ff.object_index} < obj_count_ff);
   assign dt     = $signed({1'b0, req_ff.step_time});
   assign ent    = rd_valid_ff ? rd_ff : '0;
   assign player = work_ff.flags[FLAG_PLAYER];

   // shared multiplier operand select
   always_comb begin
      mul_a = dt;
      mul_b = $signed(work_ff.accel[ax_ff]);
      case (state_ff)
         ST_PMUL: mul_b = $signed(work_ff.push[ax_ff]);
         ST_BMUL: mul_b = t_ff;
         ST_DMUL: mul_a = DRAG_Q;
         default: ;
      endcase
      prod_in = mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      req_in       = req_ff;
      work_in      = work_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      t_in         = t_ff;
      diff_in      = diff_ff;
      base_in      = base_ff;
      mem_we       = 1'b0;
      mem_wdata    = work_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            rsp_data_in = '0;
            state_in    = ST_IDLE;
            mem_wdata   = ent;
            if (!idx_ok) begin
               rsp_valid_in = 1'b1;
            end else begin
               rsp_data_in.ok = 1'b1;
               work_in        = ent;
               ax_in          = 2'd0;
               unique case (req_ff.action)
                  ACT_SET_FLAGS: begin
                     mem_wdata.flags = req_ff.flag_bits;
                     mem_we          = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_SET_ACCEL: begin
                     mem_wdata.accel = {req_ff.vec_z, req_ff.vec_y, req_ff.vec_x};
                     mem_we          = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_ADD_FORCE: begin
                     mem_wdata.accel[0] = sat_add($signed(ent.accel[0]), req_ff.vec_x);
                     mem_wdata.accel[1] = sat_add($signed(ent.accel[1]), req_ff.vec_y);
                     mem_wdata.accel[2] = sat_add($signed(ent.accel[2]), req_ff.vec_z);
                     mem_we             = 1'b1;
                     rsp_valid_in       = 1'b1;
                  end
                  ACT_PUSH: begin
                     mem_wdata.push[0] = sat_add($signed(ent.push[0]), req_ff.vec_x);
                     mem_wdata.push[1] = sat_add($signed(ent.push[1]), req_ff.vec_y);
                     mem_wdata.push[2] = sat_add($signed(ent.push[2]), req_ff.vec_z);
                     mem_we            = 1'b1;
                     rsp_valid_in      = 1'b1;
                  end
                  ACT_CLEAR: begin
                     mem_wdata.last  = '0;
                     mem_wdata.accel = '0;
                     mem_wdata.flags = '0;
                     mem_we          = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_SYNC: begin
                     mem_wdata.last  = {req_ff.vec_z, req_ff.vec_y, req_ff.vec_x};
                     mem_wdata.accel = '0;
                     mem_we          = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_INTEGRATE: begin
                     cur_in = {req_ff.vec_z, req_ff.vec_y, req_ff.vec_x};
                     if (req_ff.step_time == '0 || ent.flags[FLAG_STATIC]) begin
                        // nothing moves: echo the position
                        rsp_data_in.pos_x = req_ff.vec_x;
                        rsp_data_in.pos_y = req_ff.vec_y;
                        rsp_data_in.pos_z = req_ff.vec_z;
                        rsp_valid_in      = 1'b1;
                     end else begin
                        state_in = ent.flags[FLAG_PLAYER] ? ST_PMUL : ST_AMUL;
                     end
                  end
                  ACT_RESET_FORCE: begin
                     if (req_ff.step_time == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        if (ent.flags[FLAG_NO_GRAVITY] || ent.flags[FLAG_STATIC]) begin
                           mem_wdata.accel = '0;
                        end else begin
                           mem_wdata.accel = {grav_z_ff, grav_y_ff, grav_x_ff};
                        end
                        work_in.accel = mem_wdata.accel;
                        if (ent.flags[FLAG_DRAG] && !ent.flags[FLAG_STATIC]) begin
                           state_in = ST_DMUL;
                        end else begin
                           mem_we       = 1'b1;
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         // player push: d = dt*push applied to cur and last
         ST_PMUL: state_in = ST_PRND;
         ST_PRND: begin
            t_in     = round_sat(prod_ff);
            state_in = ST_PADD;
         end
         ST_PADD: begin
            cur_in[ax_ff]       = sat_add($signed(cur_ff[ax_ff]), t_ff);
            work_in.last[ax_ff] = sat_add($signed(work_ff.last[ax_ff]), t_ff);
            state_in            = ST_AMUL;
         end
         // Verlet step: cur + (cur - last) + dt*(dt*accel)
         ST_AMUL: begin
            diff_in  = sat_sub($signed(cur_ff[ax_ff]), $signed(work_ff.last[ax_ff]));
            state_in = ST_ARND;
         end
         ST_ARND: begin
            t_in     = round_sat(prod_ff);
            base_in  = sat_add($signed(cur_ff[ax_ff]), diff_ff);
            state_in = ST_BMUL;
         end
         ST_BMUL: state_in = ST_BRND;
         ST_BRND: begin
            t_in     = round_sat(prod_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            pos_in[ax_ff] = sat_add(base_ff, t_ff);
            ax_in         = ax_ff + 2'd1;
            if (ax_ff == 2'd2) state_in = ST_WB;
            else state_in = player ? ST_PMUL : ST_AMUL;
         end
         // drag: accel -= accel*0.02
         ST_DMUL: state_in = ST_DRND;
         ST_DRND: begin
            t_in     = round_sat(prod_ff);
            state_in = ST_DSUB;
         end
         ST_DSUB: begin
            work_in.accel[ax_ff] = sat_sub($signed(work_ff.accel[ax_ff]), t_ff);
            ax_in                = ax_ff + 2'd1;
            state_in             = (ax_ff == 2'd2) ? ST_WB : ST_DMUL;
         end
         ST_WB: begin
            mem_we       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in.ok = 1'b1;
            if (req_ff.action == ACT_INTEGRATE) begin
               mem_wdata.last = cur_ff;
               if (player) mem_wdata.push = '0;
               rsp_data_in.pos_x = pos_ff[0];
               rsp_data_in.pos_y = pos_ff[1];
               rsp_data_in.pos_z = pos_ff[2];
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[req_ff.object_index] <= mem_wdata;
      rd_ff <= mem[req_ff.object_index];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= 2'd0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         grav_x_ff    <= '0;
         grav_y_ff    <= GRAVITY_Y_RESET;
         grav_z_ff    <= '0;
         obj_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= valid_ff[req_ff.object_index];
         if (mem_we) valid_ff[req_ff.object_index] <= 1'b1;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_GRAVITY_X: grav_x_ff    <= csr_wdata;
               CSR_GRAVITY_Y: grav_y_ff    <= csr_wdata;
               CSR_GRAVITY_Z: grav_z_ff    <= csr_wdata;
               CSR_OBJ_COUNT: obj_count_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      work_ff     <= work_in;
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      t_ff        <= t_in;
      diff_ff     <= diff_in;
      base_ff     <= base_in;
   end

endmodule

/* src/vpt_checker.sv */
// Port-level checks on the particle table's command and result beats.
// Depends on vpt_pkg and verlet_particle_table_defines.svh; bound to the table.
`include "verlet_particle_table_defines.svh"

module vpt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input vpt_pkg::req_type req_data,
   input logic             rsp_valid,
   input vpt_pkg::rsp_type rsp_data,
   input logic             csr_we,
   input logic [vpt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input logic [31:0]      csr_wdata
);
   import vpt_pkg::*;

   // an accepted command keeps the block busy
   `VPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

   // a result beat is shown only once the block is free
   `VPT_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy, "result beat while busy")

   // every command's end (busy falling) comes with a result beat
   `VPT_ASSERT_NOW(a_done_rsp, $fell(busy), rsp_valid, "busy dropped without a result beat")

   // a rejected command reports zero positions
   `VPT_ASSERT_NOW(a_nok_zero, rsp_valid && !rsp_data.ok,
      rsp_data.pos_x == 0 && rsp_data.pos_y == 0 && rsp_data.pos_z == 0,
      "rejected beat carries a position")

endmodule

bind verlet_particle_table vpt_checker u_vpt_checker (.*);
